@@ src/lnh_pkg.sv @@
`timescale 1ns / 1ps

package lnh_pkg;

  // Fixed field widths of the stream payload
  localparam int LETTER_W  = 5;
  localparam int BYTE_W    = 8;
  localparam int SEL_W     = 2;
  localparam int IDX_W     = 15;
  localparam int DEPTH_W   = 2;
  localparam int OUT_W     = 32;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 64;

  // Byte codes of the letter ranges
  localparam logic [BYTE_W-1:0] CHAR_LO_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LO_Z = 8'h7a;
  localparam logic [BYTE_W-1:0] CHAR_UP_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UP_Z = 8'h5a;

  // Request kinds carried in tuser
  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Table select codes
  localparam logic [SEL_W-1:0] TSEL_SINGLE = 2'd0;
  localparam logic [SEL_W-1:0] TSEL_PAIR   = 2'd1;
  localparam logic [SEL_W-1:0] TSEL_TRIPLE = 2'd2;

  // Depth codes
  localparam logic [DEPTH_W-1:0] DEPTH_PAIRS   = 2'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_TRIPLES = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;   // write zero at the sweep address
    logic latch;    // capture an accepted request
    logic rd_en;    // read the tables for the captured request
    logic commit;   // write back, update history, load the result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last; // sweep is at its last entry
    logic out_stall; // result register full and not taken
  } ctrl_sts_t;

endpackage

@@ src/lnh_ctrl.sv @@
`timescale 1ns / 1ps

module lnh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  lnh_pkg::ctrl_sts_t sts_i,
  output lnh_pkg::ctrl_cmd_t cmd_o
);
  import lnh_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_UPD   = 2'd3;

  logic [1:0] state_q, state_d;

  // Sequence: clear sweep, then accept, read, write back
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_UPD;
      end
      ST_UPD: begin
        if (!sts_i.out_stall) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Commit only once the result register can take the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !sts_i.out_stall)
    else $error("commit while result register stalled");

  // A request is always followed by a table read in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |=> cmd_o.rd_en)
    else $error("accepted request not read");

  // Sweep and request handling never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_wr |-> !s_axis_tready && !cmd_o.commit)
    else $error("request handling during clear sweep");

endmodule

@@ src/lnh_datapath.sv @@
`timescale 1ns / 1ps

module lnh_datapath #(
  parameter int ALPHABET_SIZE = 26,
  parameter int COUNT_BITS    = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lnh_pkg::DEPTH_W-1:0]       cfg_wdata_i,
  input  logic                              req_cmd_i,
  input  logic [lnh_pkg::BYTE_W-1:0]        req_byte_i,
  input  logic [lnh_pkg::SEL_W-1:0]         req_sel_i,
  input  logic [lnh_pkg::IDX_W-1:0]         req_idx_i,
  input  lnh_pkg::ctrl_cmd_t                cmd_i,
  output lnh_pkg::ctrl_sts_t                sts_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lnh_pkg::OUT_W-1:0]         count_value_o,
  output logic [lnh_pkg::OUT_W-1:0]         letters_total_o,
  output logic                              letter_accepted_o
);
  import lnh_pkg::*;

  localparam int ASZ2 = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int ASZ3 = ASZ2 * ALPHABET_SIZE;
  localparam int SA_W = $clog2(ALPHABET_SIZE);
  localparam int PA_W = $clog2(ASZ2);
  localparam int TA_W = $clog2(ASZ3);
  localparam logic [IDX_W:0] SIZE1 = (IDX_W + 1)'(ALPHABET_SIZE);
  localparam logic [IDX_W:0] SIZE2 = (IDX_W + 1)'(ASZ2);
  localparam logic [IDX_W:0] SIZE3 = (IDX_W + 1)'(ASZ3);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Captured request
  logic               cmd_q;
  logic [BYTE_W-1:0]  byte_q;
  logic [SEL_W-1:0]   sel_q;
  logic [IDX_W-1:0]   idx_q;

  // Letter history and configuration
  logic [LETTER_W-1:0]   prev_q, prevprev_q;
  logic [COUNT_BITS-1:0] total_q;
  logic [DEPTH_W-1:0]    depth_q;
  logic [TA_W-1:0]       clr_cnt_q;

  // Tables
  logic [COUNT_BITS-1:0] single_mem [ALPHABET_SIZE];
  logic [COUNT_BITS-1:0] pair_mem   [ASZ2];
  logic [COUNT_BITS-1:0] triple_mem [ASZ3];
  logic [COUNT_BITS-1:0] single_rd_q, pair_rd_q, triple_rd_q;

  // Result register
  logic              out_valid_q;
  logic [OUT_W-1:0]  count_q, total_out_q;
  logic              acc_out_q;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= req_cmd_i;
      byte_q <= req_byte_i;
      sel_q  <= req_sel_i;
      idx_q  <= req_idx_i;
    end
  end

  // Decode the letter
  logic                is_lower, is_upper, accepted;
  logic [LETTER_W-1:0] cur;
  always_comb begin
    is_lower = (byte_q >= CHAR_LO_A) && (byte_q <= CHAR_LO_Z);
    is_upper = (byte_q >= CHAR_UP_A) && (byte_q <= CHAR_UP_Z);
    if (is_lower) begin
      cur = LETTER_W'(byte_q - CHAR_LO_A);
    end else begin
      cur = LETTER_W'(byte_q - CHAR_UP_A);
    end
    accepted = (cmd_q == CMD_FEED) && (is_lower || is_upper) &&
               (cur < LETTER_W'(ALPHABET_SIZE));
  end

  // Table addresses for a feed
  logic [IDX_W-1:0] pair_full, triple_full;
  always_comb begin
    pair_full   = IDX_W'(prev_q) * IDX_W'(ALPHABET_SIZE) + IDX_W'(cur);
    triple_full = IDX_W'(prevprev_q) * IDX_W'(ASZ2) + pair_full;
  end

  logic pair_en, triple_en;
  assign pair_en   = (depth_q >= DEPTH_PAIRS) && (total_q != '0);
  assign triple_en = (depth_q == DEPTH_TRIPLES) && (total_q[COUNT_BITS-1:1] != '0);

  // Select addresses: sweep, read request or feed
  logic [SA_W-1:0] s_addr;
  logic [PA_W-1:0] p_addr;
  logic [TA_W-1:0] t_addr;
  always_comb begin
    priority if (cmd_i.clr_wr) begin
      s_addr = clr_cnt_q[SA_W-1:0];
      p_addr = clr_cnt_q[PA_W-1:0];
      t_addr = clr_cnt_q;
    end else if (cmd_q == CMD_READ) begin
      s_addr = idx_q[SA_W-1:0];
      p_addr = idx_q[PA_W-1:0];
      t_addr = idx_q[TA_W-1:0];
    end else begin
      s_addr = cur[SA_W-1:0];
      p_addr = pair_full[PA_W-1:0];
      t_addr = triple_full[TA_W-1:0];
    end
  end

  // Write enables and data
  logic                  s_we, p_we, t_we;
  logic [COUNT_BITS-1:0] s_wd, p_wd, t_wd;
  logic                  wr_feed;
  always_comb begin
    wr_feed = cmd_i.commit && accepted;
    s_we = (cmd_i.clr_wr && ({1'b0, clr_cnt_q} < TA_W'(ALPHABET_SIZE) + (TA_W + 1)'(0)))
           || wr_feed;
    p_we = (cmd_i.clr_wr && ((TA_W + 1)'(clr_cnt_q) < (TA_W + 1)'(ASZ2)))
           || (wr_feed && pair_en);
    t_we = cmd_i.clr_wr || (wr_feed && pair_en && triple_en);
    s_wd = cmd_i.clr_wr ? '0 : sat_inc(single_rd_q);
    p_wd = cmd_i.clr_wr ? '0 : sat_inc(pair_rd_q);
    t_wd = cmd_i.clr_wr ? '0 : sat_inc(triple_rd_q);
  end

  // Table memories
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      single_mem[s_addr] <= s_wd;
    end
    if (cmd_i.rd_en) begin
      single_rd_q <= single_mem[s_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pair_mem[p_addr] <= p_wd;
    end
    if (cmd_i.rd_en) begin
      pair_rd_q <= pair_mem[p_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      triple_mem[t_addr] <= t_wd;
    end
    if (cmd_i.rd_en) begin
      triple_rd_q <= triple_mem[t_addr];
    end
  end

  // Select the read value and the next letter total; clip both to the output width
  logic [COUNT_BITS-1:0] read_val, total_d;
  logic [OUT_W-1:0]      read_clip, total_clip;
  always_comb begin
    read_val = '0;
    if (cmd_q == CMD_READ) begin
      priority if ((sel_q == TSEL_SINGLE) && ({1'b0, idx_q} < SIZE1)) begin
        read_val = single_rd_q;
      end else if ((sel_q == TSEL_PAIR) && ({1'b0, idx_q} < SIZE2)) begin
        read_val = pair_rd_q;
      end else if ((sel_q == TSEL_TRIPLE) && ({1'b0, idx_q} < SIZE3)) begin
        read_val = triple_rd_q;
      end else begin
        read_val = '0;
      end
    end
    total_d = accepted ? sat_inc(total_q) : total_q;
  end

  generate
    if (COUNT_BITS > OUT_W) begin : g_clip
      assign read_clip  = (|read_val[COUNT_BITS-1:OUT_W]) ? '1 : read_val[OUT_W-1:0];
      assign total_clip = (|total_d[COUNT_BITS-1:OUT_W]) ? '1 : total_d[OUT_W-1:0];
    end else begin : g_ext
      assign read_clip  = OUT_W'(read_val);
      assign total_clip = OUT_W'(total_d);
    end
  endgenerate

  // History, total, depth and sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      prevprev_q <= '0;
      total_q    <= '0;
      depth_q    <= DEPTH_W'(1);
      clr_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        depth_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (wr_feed) begin
        prevprev_q <= prev_q;
        prev_q     <= cur;
        total_q    <= total_d;
      end
    end
  end

  // Result register: load on commit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      count_q     <= read_clip;
      total_out_q <= total_clip;
      acc_out_q   <= accepted;
    end
  end

  assign sts_o.clr_last  = (clr_cnt_q == TA_W'(ASZ3 - 1));
  assign sts_o.out_stall = out_valid_q && !m_axis_tready;

  assign m_axis_tvalid     = out_valid_q;
  assign count_value_o     = count_q;
  assign letters_total_o   = total_out_q;
  assign letter_accepted_o = acc_out_q;

  // Letter total never decreases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> total_q >= $past(total_q))
    else $error("letter total decreased");

  // A counted letter never carries a read value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && acc_out_q |-> count_q == '0)
    else $error("feed result carries a count");

  // History moves only with a counted letter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_feed |=> $stable(prev_q) && $stable(total_q))
    else $error("history changed without a letter");

endmodule

@@ src/letter_ngram_histogram_top.sv @@
`timescale 1ns / 1ps
// Letter n-gram histogram.
// Input stream s_axis: tuser selects feed (0) or read (1). A feed carries one
// text byte; letters are folded to lower case and counted as singles, and as
// pairs and triples as far as the configured depth allows. A read returns one
// count from the table chosen by table_select at entry_index.
// Output stream m_axis: one result per request with the count read (0 for a
// feed), the saturated letter total and, in tuser, whether a letter counted.
// Configuration: cfg_we_i writes the depth (1 singles, 2 pairs, 3 triples)
// from cfg_wdata_i; write it only while no request is in flight.
// Sequence: a request is accepted, the tables are read, then the count is
// written back into the table memories and the result register is loaded,
// which raises m_axis_tvalid. The block accepts no new request until that
// write back is done.
// Reset: all tables are zeroed by a sweep over the ALPHABET_SIZE^3 addresses
// of the triple table (17576 at the default); s_axis_tready stays low
// until the sweep ends. Configuration writes are taken during the sweep.
// Stall: a result waits in the output register; the next request is still
// accepted and read, and its write back holds until the register is free.
module letter_ngram_histogram_top #(
  parameter int ALPHABET_SIZE = 26,
  parameter int COUNT_BITS    = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lnh_pkg::DEPTH_W-1:0]       cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] text_byte, [9:8] table_select, [24:10] entry_index, [31:25] zero
  input  logic [lnh_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [0] cmd
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] count_value, [63:32] letters_total
  output logic [lnh_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // [0] letter_accepted
  output logic                              m_axis_tuser
);
  import lnh_pkg::*;

  ctrl_cmd_t        cmd;
  ctrl_sts_t        sts;
  logic [OUT_W-1:0] count_value, letters_total;

  lnh_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  lnh_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_BITS    (COUNT_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_cmd_i         (s_axis_tuser),
    .req_byte_i        (s_axis_tdata[7:0]),
    .req_sel_i         (s_axis_tdata[9:8]),
    .req_idx_i         (s_axis_tdata[24:10]),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .count_value_o     (count_value),
    .letters_total_o   (letters_total),
    .letter_accepted_o (m_axis_tuser)
  );

  assign m_axis_tdata = {letters_total, count_value};

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import lnh_pkg::*;

  localparam int ALPHA  = 26;
  localparam int PAIRS  = ALPHA * ALPHA;
  localparam int TRIPS  = ALPHA * ALPHA * ALPHA;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 240;

  // Codes the package leaves out
  localparam logic [SEL_W-1:0]   TSEL_NONE     = 2'd3;
  localparam logic [DEPTH_W-1:0] DEPTH_ZERO    = 2'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_SINGLES = 2'd1;

  // One result as the block should return it
  typedef struct packed {
    logic [OUT_W-1:0] count;
    logic [OUT_W-1:0] total;
    logic             letter;
  } tally_result_t;

  // Letter n-gram counts mirrored request by request
  class ngram_tally;
    bit [OUT_W-1:0]    singles [ALPHA];
    bit [OUT_W-1:0]    pairs   [PAIRS];
    bit [OUT_W-1:0]    triples [TRIPS];
    bit [LETTER_W-1:0] prev_l;
    bit [LETTER_W-1:0] prevprev_l;
    bit [OUT_W-1:0]    total;
    bit [DEPTH_W-1:0]  depth;
    tally_result_t     pending_q[$];
    int mismatches;
    int feeds;
    int letters;
    int reads;
    int nonzero_reads;

    function new();
      depth = DEPTH_SINGLES;
    endfunction

    function bit [OUT_W-1:0] bump(bit [OUT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void count_request(bit cmd, bit [BYTE_W-1:0] text_b, bit [SEL_W-1:0] sel,
                                bit [IDX_W-1:0] idx);
      tally_result_t r;
      bit [LETTER_W-1:0] cur;
      bit is_letter;
      int p;
      int t;
      r = '0;
      cur = '0;
      if (cmd == CMD_FEED) begin
        feeds++;
        is_letter = 1'b1;
        if (text_b >= CHAR_LO_A && text_b <= CHAR_LO_Z) begin
          cur = LETTER_W'(text_b - CHAR_LO_A);
        end else if (text_b >= CHAR_UP_A && text_b <= CHAR_UP_Z) begin
          cur = LETTER_W'(text_b - CHAR_UP_A);
        end else begin
          is_letter = 1'b0;
        end
        if (is_letter) begin
          letters++;
          r.letter = 1'b1;
          total = bump(total);
          singles[cur] = bump(singles[cur]);
          // pair and triple gates look at the running total, not the depth history
          if (depth >= DEPTH_PAIRS && total > 1) begin
            p = int'(prev_l) * ALPHA + int'(cur);
            pairs[p] = bump(pairs[p]);
            if (depth == DEPTH_TRIPLES && total > 2) begin
              t = int'(prevprev_l) * PAIRS + p;
              triples[t] = bump(triples[t]);
            end
          end
          prevprev_l = prev_l;
          prev_l = cur;
        end
      end else begin
        reads++;
        case (sel)
          TSEL_SINGLE: if (idx < ALPHA) r.count = singles[idx];
          TSEL_PAIR:   if (idx < PAIRS) r.count = pairs[idx];
          TSEL_TRIPLE: if (idx < TRIPS) r.count = triples[idx];
          default:     r.count = '0;
        endcase
        if (r.count != 0) nonzero_reads++;
      end
      r.total = total;
      pending_q.push_back(r);
    endfunction

    // Compare one returned result with the oldest queued one
    function void match_result(bit [M_TDATA_W-1:0] data, bit user);
      tally_result_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result count=%0d total=%0d letter=%0b",
                   $realtime, data[31:0], data[63:32], user);
        return;
      end
      want = pending_q.pop_front();
      if (data[31:0] != want.count || data[63:32] != want.total || user != want.letter) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp count=%0d total=%0d letter=%0b, got %0d %0d %0b",
                   $realtime, want.count, want.total, want.letter,
                   data[31:0], data[63:32], user);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [DEPTH_W-1:0]     cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tuser;

  ngram_tally tally = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;

  letter_ngram_histogram_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Hard stop if the run hangs
  initial begin
    #500_000;
    $display("tb: failure");
    $finish;
  end

  // Track accepted requests and returned results
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      tally.count_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[9:8],
                          s_axis_tdata[24:10]);
    if (m_axis_tvalid && m_axis_tready)
      tally.match_result(m_axis_tdata, m_axis_tuser);
  end

  // Stall the result side in bursts of random length
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      stall_left = $urandom_range(0, 10);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Offer one request, maybe after an idle burst, and hold it until taken
  task automatic send_request(bit cmd, bit [BYTE_W-1:0] text_b, bit [SEL_W-1:0] sel,
                              bit [IDX_W-1:0] idx);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {7'd0, idx, sel, text_b};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic feed_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_request(CMD_FEED, s[i], SEL_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic read_entry(bit [SEL_W-1:0] sel, bit [IDX_W-1:0] idx);
    send_request(CMD_READ, BYTE_W'($urandom), sel, idx);
  endtask

  // Wait for every queued result, then change the depth
  task automatic write_depth(bit [DEPTH_W-1:0] d);
    s_axis_tvalid = 1'b0;
    while (tally.pending_q.size() != 0) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = d;
    tally.depth = d;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    bit [DEPTH_W-1:0] phase_depth [PHASES] = '{DEPTH_PAIRS, DEPTH_ZERO, DEPTH_TRIPLES,
                                               DEPTH_SINGLES, DEPTH_TRIPLES};
    int phase_send [PHASES] = '{20, 0, 35, 10, 0};
    int phase_recv [PHASES] = '{20, 0, 10, 35, 0};
    int roll;
    int a;
    int b;
    int c;
    bit [SEL_W-1:0] sel;
    bit [IDX_W-1:0] idx;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset depth counts singles only
    feed_text("Ab");
    read_entry(TSEL_PAIR, IDX_W'(1));

    // Letter range edges and non-letters at full depth
    write_depth(DEPTH_TRIPLES);
    feed_text("zZ@[`{");
    send_request(CMD_FEED, 8'h00, TSEL_SINGLE, '0);
    send_request(CMD_FEED, 8'hFF, TSEL_NONE, '1);
    feed_text("a");
    read_entry(TSEL_SINGLE, IDX_W'(25));
    read_entry(TSEL_PAIR, IDX_W'(PAIRS - 1));
    read_entry(TSEL_TRIPLE, IDX_W'(1 * PAIRS + 25 * ALPHA + 25));
    read_entry(TSEL_TRIPLE, IDX_W'(25 * PAIRS + 25 * ALPHA));
    read_entry(TSEL_TRIPLE, IDX_W'(TRIPS - 1));
    read_entry(TSEL_SINGLE, IDX_W'(ALPHA));
    read_entry(TSEL_PAIR, IDX_W'(PAIRS));
    read_entry(TSEL_TRIPLE, IDX_W'(TRIPS));
    read_entry(TSEL_TRIPLE, '1);
    read_entry(TSEL_NONE, '0);
    read_entry(TSEL_PAIR, '0);

    // Random text with reads aimed at entries likely to be nonzero
    for (int ph = 0; ph < PHASES; ph++) begin
      write_depth(phase_depth[ph]);
      send_idle_pct = phase_send[ph];
      recv_idle_pct = phase_recv[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        a = $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(0, 25);
        b = $urandom_range(0, 5);
        c = $urandom_range(0, 5);
        if (roll < 60) begin
          send_request(CMD_FEED,
                       BYTE_W'(($urandom_range(0, 1) ? CHAR_UP_A : CHAR_LO_A) + a),
                       SEL_W'($urandom), IDX_W'($urandom));
        end else if (roll < 70) begin
          send_request(CMD_FEED, BYTE_W'($urandom), SEL_W'($urandom), IDX_W'($urandom));
        end else if (roll < 92) begin
          sel = SEL_W'($urandom_range(0, 2));
          case (sel)
            TSEL_SINGLE: idx = IDX_W'(a);
            TSEL_PAIR:   idx = IDX_W'(b * ALPHA + a);
            default:     idx = IDX_W'(c * PAIRS + b * ALPHA + a);
          endcase
          read_entry(sel, idx);
        end else begin
          read_entry(SEL_W'($urandom), IDX_W'($urandom));
        end
      end
    end

    // Drain and let the pipeline settle
    s_axis_tvalid = 1'b0;
    while (tally.pending_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Run fed %0d bytes (%0d letters) and made %0d reads, %0d of them nonzero,",
             tally.feeds, tally.letters, tally.reads, tally.nonzero_reads);
    $display("over depths 1, 3, 2, 0, 3, 1, 3; %0d mismatches, %0d results outstanding",
             tally.mismatches, tally.pending_q.size());
    if (tally.mismatches == 0 && tally.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
